// File: rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// shared types and constants of the text console cursor engine
// ----------------------------------------------------------------------------
package tcce_pkg;

  // register indexes of the configuration port
  localparam int unsigned RegIdxW = 8;
  localparam logic [RegIdxW-1:0] REG_COLUMNS = 8'd0;
  localparam logic [RegIdxW-1:0] REG_ROWS    = 8'd1;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd25;

  // control characters and printable range
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd126;
  localparam logic [6:0] GLYPH_SPACE = 7'd32;

  // depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_LF,
    OP_CR,
    OP_BS,
    OP_TAB,
    OP_PRINT
  } op_e;

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL
  } state_e;

  // one classified item in the queue
  typedef struct packed {
    op_e        op;
    logic [6:0] glyph;
  } entry_t;

  // one result beat
  typedef struct packed {
    cmd_e       command;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic [6:0] glyph;
    logic       last_of_run;
  } result_t;

  // screen geometry handed to the back part
  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
    logic       home;
  } geom_t;

endpackage

// File: rtl/tcce_if.sv
// ----------------------------------------------------------------------------
// tcce channel interfaces
// input, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface tcce_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface tcce_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] cell_col;
  logic [7:0] cell_row;
  logic [6:0] glyph;
  logic       last_of_run;

  modport source (output valid, output command, output cell_col, output cell_row,
                  output glyph, output last_of_run, input ready);
  modport sink   (input valid, input command, input cell_col, input cell_row,
                  input glyph, input last_of_run, output ready);
endinterface

interface tcce_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// accepts input beats and classifies them into queue entries
// ----------------------------------------------------------------------------
module tcce_front (
  tcce_in_if.sink          in_ch,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output tcce_pkg::entry_t push_entry_o
);

  logic keep;

  assign in_ch.ready = push_ready_i;

  always_comb begin
    keep = 1'b1;
    push_entry_o.op    = tcce_pkg::OP_PRINT;
    push_entry_o.glyph = in_ch.char_code[6:0];
    if (in_ch.action) begin
      push_entry_o.op = tcce_pkg::OP_CLEAR;
    end else begin
      case (in_ch.char_code)
        tcce_pkg::CHAR_LF:  push_entry_o.op = tcce_pkg::OP_LF;
        tcce_pkg::CHAR_CR:  push_entry_o.op = tcce_pkg::OP_CR;
        tcce_pkg::CHAR_BS:  push_entry_o.op = tcce_pkg::OP_BS;
        tcce_pkg::CHAR_TAB: begin
          push_entry_o.op    = tcce_pkg::OP_TAB;
          push_entry_o.glyph = tcce_pkg::GLYPH_SPACE;
        end
        default: begin
          // other non-printable bytes are dropped here
          keep = (in_ch.char_code >= tcce_pkg::CHAR_FIRST) &&
                 (in_ch.char_code <= tcce_pkg::CHAR_LAST);
        end
      endcase
    end
  end

  assign push_valid_o = in_ch.valid && keep;

endmodule

// File: rtl/tcce_queue.sv
// ----------------------------------------------------------------------------
// tcce_queue
// short fifo between the classifying front and the executing back
// ----------------------------------------------------------------------------
module tcce_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  tcce_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output tcce_pkg::entry_t pop_entry_o
);

  tcce_pkg::entry_t              mem_q [tcce_pkg::QDepth];
  logic [tcce_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tcce_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tcce_pkg::QCntW-1:0]    cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign push_ready_o = (cnt_q != tcce_pkg::QCntW'(tcce_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tcce_pkg::QPtrW'(tcce_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tcce_pkg::QPtrW'(tcce_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: rtl/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// cursor sequencer: executes one queued entry at a time, at most one result beat per step
// ----------------------------------------------------------------------------
module tcce_back #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcce_pkg::geom_t  geom_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  tcce_pkg::entry_t pop_entry_i,
  tcce_out_if.source       out_ch
);

  localparam int unsigned ModW = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;
  localparam logic [ModW-1:0] ModMax = ModW'(TAB_STOP - 1);

  tcce_pkg::state_e  state_q, state_d;
  tcce_pkg::op_e     op_q;
  logic [6:0]        glyph_q;
  logic [7:0]        col_q, col_d;
  logic [7:0]        row_q, row_d;
  logic [ModW-1:0]   mod_q, mod_d;
  logic              out_valid_q, out_valid_d;
  tcce_pkg::result_t out_q, out_d;

  logic              can_emit, emit, done, to_scroll;
  logic [8:0]        col_inc, row_inc;
  logic              wrap, bottom;
  logic [ModW-1:0]   mod_inc;

  assign can_emit    = !out_valid_q || out_ch.ready;
  assign pop_ready_o = (state_q == tcce_pkg::ST_IDLE);
  assign col_inc     = {1'b0, col_q} + 9'd1;
  assign row_inc     = {1'b0, row_q} + 9'd1;
  assign wrap        = col_inc >= {1'b0, geom_i.cols};
  assign bottom      = row_inc >= {1'b0, geom_i.rows};
  assign mod_inc     = (mod_q == ModMax) ? '0 : mod_q + 1'b1;

  // datapath of one step
  always_comb begin
    emit      = 1'b0;
    done      = 1'b0;
    to_scroll = 1'b0;
    col_d     = col_q;
    row_d     = row_q;
    mod_d     = mod_q;
    out_d     = out_q;
    if (state_q == tcce_pkg::ST_EXEC && can_emit) begin
      out_d.cell_col    = '0;
      out_d.cell_row    = '0;
      out_d.glyph       = '0;
      out_d.last_of_run = 1'b1;
      case (op_q)
        tcce_pkg::OP_CLEAR: begin
          emit          = 1'b1;
          done          = 1'b1;
          out_d.command = tcce_pkg::CMD_CLEAR;
          col_d         = '0;
          row_d         = '0;
          mod_d         = '0;
        end
        tcce_pkg::OP_LF: begin
          done  = 1'b1;
          col_d = '0;
          mod_d = '0;
          out_d.command = tcce_pkg::CMD_SCROLL;
          if (bottom) begin
            emit  = 1'b1;
            row_d = geom_i.rows - 8'd1;
          end else begin
            row_d = row_inc[7:0];
          end
        end
        tcce_pkg::OP_CR: begin
          done  = 1'b1;
          col_d = '0;
          mod_d = '0;
        end
        tcce_pkg::OP_BS: begin
          done          = 1'b1;
          out_d.command = tcce_pkg::CMD_ERASE;
          out_d.cell_col = col_q - 8'd1;
          out_d.cell_row = row_q;
          if (col_q != '0) begin
            emit  = 1'b1;
            col_d = col_q - 8'd1;
            mod_d = (mod_q == '0) ? ModMax : mod_q - 1'b1;
          end
        end
        default: begin
          // print or tab: one draw at the cursor
          emit           = 1'b1;
          out_d.command  = tcce_pkg::CMD_DRAW;
          out_d.cell_col = col_q;
          out_d.cell_row = row_q;
          out_d.glyph    = glyph_q;
          if (wrap) begin
            col_d = '0;
            mod_d = '0;
            if (bottom) begin
              to_scroll         = 1'b1;
              out_d.last_of_run = 1'b0;
            end else begin
              row_d = row_inc[7:0];
              done  = 1'b1;
            end
          end else begin
            col_d = col_inc[7:0];
            mod_d = mod_inc;
            done  = (op_q == tcce_pkg::OP_PRINT) || (mod_inc == '0);
            out_d.last_of_run = done;
          end
        end
      endcase
    end else if (state_q == tcce_pkg::ST_SCROLL && can_emit) begin
      emit              = 1'b1;
      done              = 1'b1;
      row_d             = geom_i.rows - 8'd1;
      out_d.command     = tcce_pkg::CMD_SCROLL;
      out_d.cell_col    = '0;
      out_d.cell_row    = '0;
      out_d.glyph       = '0;
      out_d.last_of_run = 1'b1;
    end
    if (geom_i.home) begin
      col_d = '0;
      row_d = '0;
      mod_d = '0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ch.ready;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcce_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = tcce_pkg::ST_EXEC;
        end
      end
      tcce_pkg::ST_EXEC: begin
        if (to_scroll) begin
          state_d = tcce_pkg::ST_SCROLL;
        end else if (done) begin
          state_d = tcce_pkg::ST_IDLE;
        end
      end
      tcce_pkg::ST_SCROLL: begin
        if (done) begin
          state_d = tcce_pkg::ST_IDLE;
        end
      end
      default: state_d = tcce_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcce_pkg::ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      mod_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      mod_q       <= mod_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_valid_i && pop_ready_o) begin
      op_q    <= pop_entry_i.op;
      glyph_q <= pop_entry_i.glyph;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.command     = out_q.command;
  assign out_ch.cell_col    = out_q.cell_col;
  assign out_ch.cell_row    = out_q.cell_row;
  assign out_ch.glyph       = out_q.glyph;
  assign out_ch.last_of_run = out_q.last_of_run;

endmodule

// File: rtl/text_console_cursor_engine_top.sv
// path: a beat is classified combinationally and enters the queue when accepted;
//   the idle back pulls one entry at a time, at most one result beat per step,
//   stalling while a beat is not taken; a tab draws up to TAB_STOP cells
// reset: columns 80, rows 25, cursor at column 0 row 0, queue and result register empty
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// cursor control for a character-cell display: turns bytes into cell commands
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcce_in_if.sink    in_ch,
  tcce_out_if.source out_ch,
  tcce_cfg_if.sink   cfg_ch
);

  // screen geometry registers
  logic [7:0]       columns_q, columns_d;
  logic [7:0]       rows_q, rows_d;
  logic             cfg_beat;
  tcce_pkg::geom_t  geom;

  // front to queue
  logic             push_valid, push_ready;
  tcce_pkg::entry_t push_entry;

  // queue to back
  logic             pop_valid, pop_ready;
  tcce_pkg::entry_t pop_entry;

  // the user must issue config writes only while idle; the block does not enforce this, the port is always open
  assign cfg_ch.ready = 1'b1;
  assign cfg_beat     = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    columns_d = columns_q;
    rows_d    = rows_q;
    geom.home = 1'b0;
    // a zero register value behaves as one
    geom.cols = (columns_q == '0) ? 8'd1 : columns_q;
    geom.rows = (rows_q == '0) ? 8'd1 : rows_q;
    if (cfg_beat) begin
      case (cfg_ch.reg_index)
        tcce_pkg::REG_COLUMNS: begin
          columns_d = cfg_ch.wdata;
          geom.home = 1'b1;
        end
        tcce_pkg::REG_ROWS: begin
          rows_d    = cfg_ch.wdata;
          geom.home = 1'b1;
        end
        default: begin
          // writes past the register list are dropped and leave the cursor alone
          geom.home = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= tcce_pkg::COLUMNS_RESET;
      rows_q    <= tcce_pkg::ROWS_RESET;
    end else begin
      columns_q <= columns_d;
      rows_q    <= rows_d;
    end
  end

  // front: classify bytes, drop the ones that do nothing
  tcce_front u_front (
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // short queue so the front keeps taking beats while a run is emitted
  tcce_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // back: owns the cursor and the registered result beat
  tcce_back #(
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_ch      (out_ch)
  );

endmodule
